### rtl/tra_pkg.sv
// ----------------------------------------------------------------------------
// tra_pkg
// Shared types and fixed-point constants for the rational tanh pipeline.
// ----------------------------------------------------------------------------
package tra_pkg;

    // fixed work format: unsigned, 20 fractional bits
    localparam int WORK_FRAC_BITS = 20;

    // port field widths
    localparam int IN_W  = 16;
    localparam int OUT_W = 16;

    // internal widths, bounded by |x| <= 5 on the formula path (s <= 25.0)
    localparam int SQ_W  = 32;              // a * a
    localparam int S_W   = 25;              // s = x^2 in work format
    localparam int XW_W  = 23;              // |x| in work format
    localparam int T1_W  = 31;              // 21 s + 1260
    localparam int T2_W  = 28;              // s + 210
    localparam int M1_W  = T1_W + S_W;      // (21 s + 1260) s
    localparam int M2_W  = T2_W + S_W;      // (s + 210) s
    localparam int P_W   = 36;              // numerator polynomial
    localparam int QA_W  = 34;              // inner denominator term
    localparam int M3_W  = QA_W + S_W;      // inner term times s
    localparam int Q_W   = 39;              // denominator polynomial
    localparam int NUM_W = XW_W + P_W;      // |x| times numerator

    // number of pipeline stages in the polynomial front end
    localparam int POLY_STAGES = 7;

    // coefficients placed in the work format
    localparam logic [T1_W-1:0] K21      = T1_W'(21);
    localparam logic [T1_W-1:0] T1_OFS   = T1_W'(64'd1260 << WORK_FRAC_BITS);
    localparam logic [T2_W-1:0] T2_OFS   = T2_W'(64'd210 << WORK_FRAC_BITS);
    localparam logic [QA_W-1:0] QA_OFS   = QA_W'(64'd4725 << WORK_FRAC_BITS);
    localparam logic [P_W-1:0]  P_OFS    = P_W'(64'd10395 << WORK_FRAC_BITS);
    localparam logic [Q_W-1:0]  Q_OFS    = Q_W'(64'd10395 << WORK_FRAC_BITS);

    // rounding offset for a product brought back to the work format
    localparam logic [63:0] HALF_LSB = 64'd1 << (WORK_FRAC_BITS - 1);

    // input transaction
    typedef struct packed {
        logic signed [IN_W-1:0] x_value;
        logic                   is_last;
    } tra_in_t;

    // result transaction
    typedef struct packed {
        logic signed [OUT_W-1:0] tanh_value;
        logic                    is_last_out;
    } tra_out_t;

    // per-item side information carried along the pipeline
    typedef struct packed {
        logic neg;
        logic sat;
        logic last;
    } tra_meta_t;

endpackage

### rtl/tra_poly.sv
// ----------------------------------------------------------------------------
// tra_poly
// Front end: magnitude, square, numerator and denominator polynomials, and
// the dividend / divisor pair for the quotient pipeline.
// ----------------------------------------------------------------------------
module tra_poly #(
    parameter int IN_FRAC_BITS  = 11,
    parameter int OUT_FRAC_BITS = 14,
    parameter int R_W           = 61,
    parameter int DEN_W         = 46
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    input  tra_pkg::tra_in_t   sample,
    output logic               quot_valid,
    output tra_pkg::tra_meta_t meta,
    output logic [R_W-1:0]     rem,
    output logic [DEN_W-1:0]   den
);
    import tra_pkg::*;

    localparam int NSTG   = POLY_STAGES;
    localparam int XW_SH  = WORK_FRAC_BITS - IN_FRAC_BITS;
    localparam int LIM_W  = IN_FRAC_BITS + 3;
    localparam int CMP_W  = (LIM_W > IN_W) ? LIM_W : IN_W;
    localparam logic [LIM_W-1:0] LIMIT = LIM_W'(5) << IN_FRAC_BITS;
    localparam int NUM_SH = (OUT_FRAC_BITS >= WORK_FRAC_BITS) ?
                            OUT_FRAC_BITS - WORK_FRAC_BITS : 0;
    localparam int DEN_SH = (OUT_FRAC_BITS < WORK_FRAC_BITS) ?
                            WORK_FRAC_BITS - OUT_FRAC_BITS : 0;

    // valid and side information per stage
    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] vld_next;
    tra_meta_t       meta_reg  [NSTG];
    tra_meta_t       meta_next [NSTG];

    // stage 1: square and scaled magnitude
    logic [IN_W-1:0]  a_mag;
    logic [SQ_W-1:0]  sq_reg, sq_next;
    logic [XW_W-1:0]  xw1_reg, xw1_next;
    // stage 2: s and the two linear terms
    logic [S_W-1:0]   s_calc;
    logic [S_W-1:0]   s2_reg, s2_next;
    logic [T1_W-1:0]  t1_reg, t1_next;
    logic [T2_W-1:0]  t2_reg, t2_next;
    logic [XW_W-1:0]  xw2_reg, xw2_next;
    // stage 3: first products
    logic [M1_W-1:0]  m1_reg, m1_next;
    logic [M2_W-1:0]  m2_reg, m2_next;
    logic [S_W-1:0]   s3_reg, s3_next;
    logic [XW_W-1:0]  xw3_reg, xw3_next;
    // stage 4: numerator and inner denominator term
    logic [P_W-1:0]   p_reg, p_next;
    logic [QA_W-1:0]  qa_reg, qa_next;
    logic [S_W-1:0]   s4_reg, s4_next;
    logic [XW_W-1:0]  xw4_reg, xw4_next;
    // stage 5: second products
    logic [M3_W-1:0]  m3_reg, m3_next;
    logic [NUM_W-1:0] num5_reg, num5_next;
    // stage 6: denominator
    logic [Q_W-1:0]   q_reg, q_next;
    logic [NUM_W-1:0] num6_reg, num6_next;
    // stage 7: dividend and divisor
    logic [R_W-1:0]   n_reg, n_next;
    logic [DEN_W-1:0] d_reg, d_next;

    // s from the exact square, rounded or shifted into the work format
    generate
        if (2 * IN_FRAC_BITS > WORK_FRAC_BITS) begin : g_s_round
            localparam int SR = 2 * IN_FRAC_BITS - WORK_FRAC_BITS;
            assign s_calc = S_W'((sq_reg + SQ_W'(64'd1 << (SR - 1))) >> SR);
        end
        else begin : g_s_shift
            localparam int SL = WORK_FRAC_BITS - 2 * IN_FRAC_BITS;
            assign s_calc = S_W'(64'(sq_reg) << SL);
        end
    endgenerate

    // valid and side information advance every cycle
    always_comb
    begin
        vld_next = {vld_reg[NSTG-2:0], item_valid};
        a_mag = sample.x_value[IN_W-1] ? (IN_W'(0) - IN_W'(sample.x_value))
                                       : IN_W'(sample.x_value);
        meta_next[0].neg  = sample.x_value[IN_W-1];
        meta_next[0].sat  = CMP_W'(a_mag) > CMP_W'(LIMIT);
        meta_next[0].last = sample.is_last;
        for (int i = 1; i < NSTG; i++)
        begin
            meta_next[i] = meta_reg[i-1];
        end
    end

    // stage 1
    always_comb
    begin
        sq_next  = SQ_W'(a_mag) * SQ_W'(a_mag);
        xw1_next = XW_W'({{WORK_FRAC_BITS{1'b0}}, a_mag} << XW_SH);
    end

    // stage 2
    always_comb
    begin
        s2_next  = s_calc;
        t1_next  = T1_W'(s_calc) * K21 + T1_OFS;
        t2_next  = T2_W'(s_calc) + T2_OFS;
        xw2_next = xw1_reg;
    end

    // stage 3
    always_comb
    begin
        m1_next  = M1_W'(t1_reg) * M1_W'(s2_reg);
        m2_next  = M2_W'(t2_reg) * M2_W'(s2_reg);
        s3_next  = s2_reg;
        xw3_next = xw2_reg;
    end

    // stage 4: round products back to the work format and add offsets
    always_comb
    begin
        p_next   = P_W'((m1_reg + M1_W'(HALF_LSB)) >> WORK_FRAC_BITS) + P_OFS;
        qa_next  = QA_W'((m2_reg + M2_W'(HALF_LSB)) >> WORK_FRAC_BITS) + QA_OFS;
        s4_next  = s3_reg;
        xw4_next = xw3_reg;
    end

    // stage 5
    always_comb
    begin
        m3_next   = M3_W'(qa_reg) * M3_W'(s4_reg);
        num5_next = NUM_W'(xw4_reg) * NUM_W'(p_reg);
    end

    // stage 6
    always_comb
    begin
        q_next    = Q_W'((m3_reg + M3_W'(HALF_LSB)) >> WORK_FRAC_BITS) + Q_OFS;
        num6_next = num5_reg;
    end

    // stage 7: dividend 2 num + den and divisor 2 den, both output scaled
    always_comb
    begin
        n_next = (R_W'(num6_reg) << (NUM_SH + 1)) + (R_W'(q_reg) << DEN_SH);
        d_next = DEN_W'(q_reg) << (DEN_SH + 1);
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        meta_reg  <= meta_next;
        sq_reg    <= sq_next;
        xw1_reg   <= xw1_next;
        s2_reg    <= s2_next;
        t1_reg    <= t1_next;
        t2_reg    <= t2_next;
        xw2_reg   <= xw2_next;
        m1_reg    <= m1_next;
        m2_reg    <= m2_next;
        s3_reg    <= s3_next;
        xw3_reg   <= xw3_next;
        p_reg     <= p_next;
        qa_reg    <= qa_next;
        s4_reg    <= s4_next;
        xw4_reg   <= xw4_next;
        m3_reg    <= m3_next;
        num5_reg  <= num5_next;
        q_reg     <= q_next;
        num6_reg  <= num6_next;
        n_reg     <= n_next;
        d_reg     <= d_next;
    end

    assign quot_valid = vld_reg[NSTG-1];
    assign meta       = meta_reg[NSTG-1];
    assign rem        = n_reg;
    assign den        = d_reg;

endmodule

### rtl/tra_div_step.sv
// ----------------------------------------------------------------------------
// tra_div_step
// One restoring division stage: decides quotient bit K with a single
// compare and subtract against the shifted divisor.
// ----------------------------------------------------------------------------
module tra_div_step #(
    parameter int R_W   = 61,
    parameter int DEN_W = 46,
    parameter int QB    = 15,
    parameter int K     = 0
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               valid,
    input  tra_pkg::tra_meta_t meta,
    input  logic [R_W-1:0]     rem,
    input  logic [DEN_W-1:0]   den,
    input  logic [QB-1:0]      quo,
    output logic               step_valid,
    output tra_pkg::tra_meta_t step_meta,
    output logic [R_W-1:0]     step_rem,
    output logic [DEN_W-1:0]   step_den,
    output logic [QB-1:0]      step_quo
);
    import tra_pkg::*;

    logic [R_W-1:0]   dsh;
    logic             ge;
    logic             vld_reg, vld_next;
    tra_meta_t        meta_reg, meta_next;
    logic [R_W-1:0]   rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [QB-1:0]    quo_reg, quo_next;

    // compare against divisor times 2^K and subtract when it fits
    always_comb
    begin
        dsh       = R_W'(den) << K;
        ge        = rem >= dsh;
        vld_next  = valid;
        meta_next = meta;
        rem_next  = ge ? (rem - dsh) : rem;
        den_next  = den;
        quo_next  = quo;
        quo_next[K] = ge;
    end

    // control register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        meta_reg <= meta_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quo_reg  <= quo_next;
    end

    assign step_valid = vld_reg;
    assign step_meta  = meta_reg;
    assign step_rem   = rem_reg;
    assign step_den   = den_reg;
    assign step_quo   = quo_reg;

endmodule

### rtl/tanh_rational_approx.sv
// ----------------------------------------------------------------------------
// tanh_rational_approx
// Pade 5/6 rational approximation of tanh on a Q4.11 sample stream,
// giving a rounded and saturated Q1.14 result.
// ----------------------------------------------------------------------------
//
// channel   direction  handshake       payload
// -------   ---------  --------------  -----------------------------------
// sample    in         start / busy    x_value (Q4.11), is_last
// result    out        done strobe     tanh_value (Q1.14), is_last_out
//
// one sample is taken every cycle; busy stays low
// each result passes from its sample through the seven polynomial stages,
// the overflow check, one restoring division stage per quotient bit and
// the output register
// rst_n clears all valid bits at once; no clearing pass is needed
// results are shown on done for one cycle and cannot be held off
//
module tanh_rational_approx #(
    parameter int IN_FRAC_BITS  = 11,
    parameter int OUT_FRAC_BITS = 14
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  tra_pkg::tra_in_t  sample,
    output logic              done,
    output tra_pkg::tra_out_t result
);
    import tra_pkg::*;

    localparam int NUM_SH  = (OUT_FRAC_BITS >= WORK_FRAC_BITS) ?
                             OUT_FRAC_BITS - WORK_FRAC_BITS : 0;
    localparam int DEN_SH  = (OUT_FRAC_BITS < WORK_FRAC_BITS) ?
                             WORK_FRAC_BITS - OUT_FRAC_BITS : 0;
    localparam int DEN_W   = Q_W + DEN_SH + 1;
    localparam int N_A     = NUM_W + NUM_SH + 1;
    localparam int N_B     = Q_W + DEN_SH;
    localparam int N_W     = ((N_A > N_B) ? N_A : N_B) + 1;
    localparam int QB      = OUT_FRAC_BITS + 1;
    localparam int R_W     = (N_W > DEN_W + QB) ? N_W : DEN_W + QB;
    localparam int MW      = (QB > OUT_W) ? QB : OUT_W;
    localparam int LATENCY = POLY_STAGES + QB + 2;
    localparam logic [QB-1:0] ONE = QB'(1) << OUT_FRAC_BITS;

    // front end outputs
    logic             pl_valid;
    tra_meta_t        pl_meta;
    logic [R_W-1:0]   pl_rem;
    logic [DEN_W-1:0] pl_den;

    // overflow check stage
    logic             ov_vld_reg, ov_vld_next;
    tra_meta_t        ov_meta_reg, ov_meta_next;
    logic [R_W-1:0]   ov_rem_reg, ov_rem_next;
    logic [DEN_W-1:0] ov_den_reg, ov_den_next;

    // division chain links
    logic             c_vld  [QB+1];
    tra_meta_t        c_meta [QB+1];
    logic [R_W-1:0]   c_rem  [QB+1];
    logic [DEN_W-1:0] c_den  [QB+1];
    logic [QB-1:0]    c_quo  [QB+1];

    // output stage
    logic [QB-1:0]    mag;
    logic [MW-1:0]    mag_ext;
    logic [MW-1:0]    val_signed;
    logic             done_reg, done_next;
    tra_out_t         result_reg, result_next;

    assign busy = 1'b0;

    tra_poly #(
        .IN_FRAC_BITS  (IN_FRAC_BITS),
        .OUT_FRAC_BITS (OUT_FRAC_BITS),
        .R_W           (R_W),
        .DEN_W         (DEN_W)
    ) u_poly (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (start),
        .sample     (sample),
        .quot_valid (pl_valid),
        .meta       (pl_meta),
        .rem        (pl_rem),
        .den        (pl_den)
    );

    // quotient of 2^QB or more saturates
    always_comb
    begin
        ov_vld_next      = pl_valid;
        ov_meta_next     = pl_meta;
        ov_meta_next.sat = pl_meta.sat || (pl_rem >= (R_W'(pl_den) << QB));
        ov_rem_next      = pl_rem;
        ov_den_next      = pl_den;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_vld_reg <= 1'b0;
        end
        else
        begin
            ov_vld_reg <= ov_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ov_meta_reg <= ov_meta_next;
        ov_rem_reg  <= ov_rem_next;
        ov_den_reg  <= ov_den_next;
    end

    assign c_vld[0]  = ov_vld_reg;
    assign c_meta[0] = ov_meta_reg;
    assign c_rem[0]  = ov_rem_reg;
    assign c_den[0]  = ov_den_reg;
    assign c_quo[0]  = '0;

    // one restoring stage per quotient bit, most significant first
    generate
        for (genvar j = 0; j < QB; j++)
        begin : g_div
            tra_div_step #(
                .R_W   (R_W),
                .DEN_W (DEN_W),
                .QB    (QB),
                .K     (QB - 1 - j)
            ) u_step (
                .clk        (clk),
                .rst_n      (rst_n),
                .valid      (c_vld[j]),
                .meta       (c_meta[j]),
                .rem        (c_rem[j]),
                .den        (c_den[j]),
                .quo        (c_quo[j]),
                .step_valid (c_vld[j+1]),
                .step_meta  (c_meta[j+1]),
                .step_rem   (c_rem[j+1]),
                .step_den   (c_den[j+1]),
                .step_quo   (c_quo[j+1])
            );
        end
    endgenerate

    // saturate to one, restore the sign
    always_comb
    begin
        mag = (c_meta[QB].sat || (c_quo[QB] > ONE)) ? ONE : c_quo[QB];
        mag_ext    = MW'(mag);
        val_signed = c_meta[QB].neg ? (MW'(0) - mag_ext) : mag_ext;
        done_next  = c_vld[QB];
        result_next.tanh_value  = $signed(val_signed[OUT_W-1:0]);
        result_next.is_last_out = c_meta[QB].last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

`ifndef SYNTHESIS
    // every accepted sample yields a result after the fixed latency
    a_start_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##LATENCY done)
        else $error("accepted sample produced no result");

    // no result without a matching sample
    a_done_from_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LATENCY))
        else $error("result without a sample");

    // last flag travels with its sample
    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.is_last_out == $past(sample.is_last, LATENCY)))
        else $error("last flag out of step with data");

    // zero maps to zero
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(sample.x_value == '0, LATENCY)) |-> (result.tanh_value == '0))
        else $error("zero input gave a nonzero result");
`endif

endmodule
